// ===== hdl/tpf_pkg.sv =====
// Shared types and constants of the trapezoid profile follower.
// Holds the request and result structs, state codes and the serial unit interface.
// Depends on nothing.
`default_nettype none

package tpf_pkg;

	// Width of the serial unit's working registers and of its divisor.
	localparam int OPW = 72;
	localparam int DVW = 32;

	typedef struct packed {
		logic               action;
		logic signed [31:0] left_count;
		logic signed [31:0] right_count;
		logic signed [31:0] heading;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] speed_cmd;
		logic signed [31:0] twist_cmd;
		logic               running;
	} rsp_t;

	localparam logic [2:0] REG_TARGET = 3'd0;
	localparam logic [2:0] REG_CVEL   = 3'd1;
	localparam logic [2:0] REG_ACCEL  = 3'd2;
	localparam logic [2:0] REG_VSCALE = 3'd3;
	localparam logic [2:0] REG_PGAIN  = 3'd4;
	localparam logic [2:0] REG_HGAIN  = 3'd5;

	localparam logic [30:0] RST_TARGET = 31'd0;
	localparam logic [30:0] RST_CVEL   = 31'd65536;
	localparam logic [30:0] RST_ACCEL  = 31'd65536;
	localparam logic [15:0] RST_VSCALE = 16'd2789;
	localparam logic [15:0] RST_PGAIN  = 16'd6554;
	localparam logic [15:0] RST_HGAIN  = 16'd2490;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_VT, ST_Q, ST_VV, ST_DR, ST_DC, ST_CM, ST_CD, ST_FIN,
		ST_SEL, ST_P, ST_T1, ST_T2M, ST_T2, ST_T3M, ST_T3, ST_MIX,
		ST_M1, ST_M2, ST_M3, ST_OUT
	} st_t;

	typedef enum logic [1:0] {
		PH_RAMP,
		PH_CRUISE,
		PH_BRAKE
	} phase_t;

	typedef enum logic {
		SER_MUL,
		SER_DIV
	} ser_op_t;

	typedef struct packed {
		logic             go;
		ser_op_t          op;
		logic [OPW-1:0]   opa;
		logic [DVW-1:0]   opb;
	} ser_req_t;

	typedef struct packed {
		logic             done;
		logic [OPW-1:0]   result;
		logic [DVW-1:0]   rem;
	} ser_rsp_t;

	// Saturate a signed value to 32 bits.
	function automatic logic signed [31:0] sat32(input logic signed [73:0] x);
		logic signed [31:0] y;
		if (x[73:31] == {43{1'b0}} || x[73:31] == {43{1'b1}}) begin
			y = x[31:0];
		end else if (x[73]) begin
			y = {1'b1, {31{1'b0}}};
		end else begin
			y = {1'b0, {31{1'b1}}};
		end
		return y;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/tpf_serial.sv =====
// Bit-serial arithmetic unit: shift-add multiply and restoring divide.
// One multiplier bit or one quotient bit per cycle; depends on tpf_pkg.
`default_nettype none

module tpf_serial (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire tpf_pkg::ser_req_t req,
	output tpf_pkg::ser_rsp_t   rsp
);

	localparam int CNT_W = $clog2(tpf_pkg::OPW);

	logic                        busy_q;
	logic                        done_q;
	tpf_pkg::ser_op_t            op_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [tpf_pkg::OPW-1:0]     x_q;
	logic [tpf_pkg::OPW-1:0]     y_q;
	logic [tpf_pkg::DVW-1:0]     m_q;
	logic [tpf_pkg::DVW-1:0]     r_q;

	logic [tpf_pkg::DVW:0]       trial;
	logic                        fits;
	logic                        mul_end;
	logic                        div_end;

	always_comb begin
		trial   = {r_q, x_q[tpf_pkg::OPW-1]};
		fits    = (trial >= {1'b0, m_q});
		mul_end = (m_q == '0);
		div_end = (cnt_q == CNT_W'(tpf_pkg::OPW - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= tpf_pkg::SER_MUL;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (op_q == tpf_pkg::SER_MUL) begin
					if (mul_end) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end else begin
					cnt_q <= cnt_q + 1'b1;
					if (div_end) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			x_q <= (req.op == tpf_pkg::SER_MUL) ? '0 : req.opa;
			y_q <= req.opa;
			m_q <= req.opb;
			r_q <= '0;
		end else if (busy_q) begin
			if (op_q == tpf_pkg::SER_MUL) begin
				if (!mul_end) begin
					if (m_q[0]) begin
						x_q <= x_q + y_q;
					end
					y_q <= {y_q[tpf_pkg::OPW-2:0], 1'b0};
					m_q <= {1'b0, m_q[tpf_pkg::DVW-1:1]};
				end
			end else begin
				// Quotient bits shift in at the bottom as dividend bits leave the top.
				if (fits) begin
					r_q <= tpf_pkg::DVW'(trial - {1'b0, m_q});
				end else begin
					r_q <= trial[tpf_pkg::DVW-1:0];
				end
				x_q <= {x_q[tpf_pkg::OPW-2:0], fits};
			end
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = x_q;
	assign rsp.rem    = r_q;

endmodule

`default_nettype wire

// ===== hdl/trapezoid_profile_follower.sv =====
// Trapezoid motion profile follower: one drive command per control tick.
// A start request and a control tick on a running profile both run through the bit-serial unit,
// whose divisions take 72 steps and whose multiplies take one step per multiplier bit; an idle
// tick skips the unit and goes straight to the output register.
// One request at a time; a finished result waits in the output register.
// Reset restores the register defaults and leaves the profile idle.
`default_nettype none

module trapezoid_profile_follower #(
	parameter int MAX_TICKS        = 65536,
	parameter int TICKS_PER_SECOND = 100
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	output logic               cmd_stall,
	input  wire tpf_pkg::cmd_t cmd,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output tpf_pkg::rsp_t      rsp,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [4:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int CW = $clog2(MAX_TICKS + 1);
	localparam logic [CW-1:0] LIM = CW'(MAX_TICKS);
	localparam logic [31:0] TPS = 32'(TICKS_PER_SECOND);
	localparam logic [31:0] DEN = 32'(2 * TICKS_PER_SECOND * TICKS_PER_SECOND);
	localparam int OPW = tpf_pkg::OPW;

	// Configuration registers.
	logic [30:0] target_q, cvel_q, accel_q;
	logic [15:0] vscale_q, pgain_q, hgain_q;

	// Control state.
	tpf_pkg::st_t    state_q, state_d;
	logic            pend_q;
	logic            run_q;
	logic [CW-1:0]   tick_q;
	logic            rsp_valid_q;
	logic            idle_tick_q;

	// Profile and working registers.
	tpf_pkg::cmd_t   cmd_q;
	tpf_pkg::rsp_t   rsp_q;
	tpf_pkg::phase_t phase_q;
	logic [30:0]     held_v_q, held_a_q, dr_q;
	logic signed [31:0] dc_q;
	logic [CW-1:0]   ramp_q, cruise_q, brake_q, x_q;
	logic            remnz_q;
	logic [OPW-1:0]  p_q, t1_q, t2_q, t3_q;
	logic signed [31:0] vel_q;
	logic signed [34:0] err2_q;

	tpf_pkg::ser_req_t ser_req;
	tpf_pkg::ser_rsp_t ser_rsp;

	logic cmd_take, cfg_write, op_state;

	tpf_serial u_serial (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ser_req),
		.rsp    (ser_rsp)
	);

	assign cmd_stall = (state_q != tpf_pkg::ST_IDLE);
	assign cmd_take  = cmd_valid && !cmd_stall;
	assign cfg_write = psel && penable && pwrite;
	assign pready    = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Register file.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= tpf_pkg::RST_TARGET;
			cvel_q   <= tpf_pkg::RST_CVEL;
			accel_q  <= tpf_pkg::RST_ACCEL;
			vscale_q <= tpf_pkg::RST_VSCALE;
			pgain_q  <= tpf_pkg::RST_PGAIN;
			hgain_q  <= tpf_pkg::RST_HGAIN;
		end else if (cfg_write) begin
			case (paddr[4:2])
				tpf_pkg::REG_TARGET: target_q <= pwdata[30:0];
				tpf_pkg::REG_CVEL:   cvel_q   <= pwdata[30:0];
				tpf_pkg::REG_ACCEL:  accel_q  <= pwdata[30:0];
				tpf_pkg::REG_VSCALE: vscale_q <= pwdata[15:0];
				tpf_pkg::REG_PGAIN:  pgain_q  <= pwdata[15:0];
				tpf_pkg::REG_HGAIN:  hgain_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			tpf_pkg::REG_TARGET: prdata = {1'b0, target_q};
			tpf_pkg::REG_CVEL:   prdata = {1'b0, cvel_q};
			tpf_pkg::REG_ACCEL:  prdata = {1'b0, accel_q};
			tpf_pkg::REG_VSCALE: prdata = {16'd0, vscale_q};
			tpf_pkg::REG_PGAIN:  prdata = {16'd0, pgain_q};
			tpf_pkg::REG_HGAIN:  prdata = {16'd0, hgain_q};
			default:             prdata = '0;
		endcase
	end

	// Combinational datapath pieces used by the states that do not call the serial unit.
	logic signed [73:0] dc_w;
	logic signed [31:0] dc_s;
	logic               q_ge, c_ge;
	logic [CW-1:0]      q_sat, c_sat, ramp_n, left1, cruise_n, left2, brake_n;
	logic [CW:0]        b_raw, rc, tick_rel;
	logic signed [73:0] vel_w, pos_w;
	logic signed [31:0] vel_s, pos_s;
	logic signed [34:0] err2_w;
	logic [CW+1:0]      total;
	logic [CW:0]        tick_nxt;
	logic [OPW-1:0]     sp_sum, tw_neg;
	logic signed [73:0] sp_ext, tw_ext;
	logic signed [31:0] speed_s, twist_s;

	always_comb begin
		dc_w  = $signed({43'd0, target_q}) - $signed({42'd0, dr_q, 1'b0});
		dc_s  = tpf_pkg::sat32(dc_w);

		// Point counts, each cut so the total stays within the tick limit.
		q_ge     = (t1_q >= OPW'(MAX_TICKS));
		q_sat    = q_ge ? LIM : t1_q[CW-1:0];
		ramp_n   = q_ge ? LIM : q_sat + 1'b1;
		c_ge     = (t3_q >= OPW'(MAX_TICKS));
		c_sat    = c_ge ? LIM : t3_q[CW-1:0];
		left1    = LIM - ramp_n;
		cruise_n = (c_sat > left1) ? left1 : c_sat;
		left2    = left1 - cruise_n;
		b_raw    = {1'b0, q_sat} + {{CW{1'b0}}, remnz_q};
		brake_n  = (b_raw > {1'b0, left2}) ? left2 : b_raw[CW-1:0];

		rc       = {1'b0, ramp_q} + {1'b0, cruise_q};
		tick_rel = {1'b0, tick_q} - rc;

		case (phase_q)
			tpf_pkg::PH_RAMP: begin
				vel_w = $signed({2'b0, t1_q});
				pos_w = $signed({2'b0, t2_q});
			end
			tpf_pkg::PH_CRUISE: begin
				vel_w = $signed({43'd0, held_v_q});
				pos_w = $signed({43'd0, dr_q}) + $signed({2'b0, t3_q});
			end
			default: begin
				vel_w = $signed({43'd0, held_v_q}) - $signed({2'b0, t1_q});
				pos_w = $signed({{42{dc_q[31]}}, dc_q}) + $signed({43'd0, dr_q})
					+ $signed({2'b0, t3_q}) - $signed({2'b0, t2_q});
			end
		endcase
		vel_s  = tpf_pkg::sat32(vel_w);
		pos_s  = tpf_pkg::sat32(pos_w);
		err2_w = $signed({{2{pos_s[31]}}, pos_s, 1'b0})
			- $signed({{3{cmd_q.left_count[31]}}, cmd_q.left_count})
			- $signed({{3{cmd_q.right_count[31]}}, cmd_q.right_count});

		total    = {2'b0, ramp_q} + {2'b0, cruise_q} + {2'b0, brake_q};
		tick_nxt = {1'b0, tick_q} + 1'b1;

		// Speed is the floored sum of twice the feedforward product and the error product.
		sp_sum  = {p_q[OPW-2:0], 1'b0} + t1_q;
		sp_ext  = $signed({{2{sp_sum[OPW-1]}}, sp_sum}) >>> 17;
		speed_s = tpf_pkg::sat32(sp_ext);
		tw_neg  = '0 - t2_q;
		tw_ext  = $signed({{2{tw_neg[OPW-1]}}, tw_neg}) >>> 16;
		twist_s = tpf_pkg::sat32(tw_ext);
	end

	// Sequencer: next state and the serial unit's request.
	always_comb begin
		state_d     = state_q;
		op_state    = 1'b1;
		ser_req.op  = tpf_pkg::SER_MUL;
		ser_req.opa = '0;
		ser_req.opb = '0;
		case (state_q)
			tpf_pkg::ST_IDLE: begin
				op_state = 1'b0;
				if (cmd_take) begin
					if (cmd.action) begin
						state_d = tpf_pkg::ST_VT;
					end else if (run_q) begin
						state_d = tpf_pkg::ST_SEL;
					end else begin
						state_d = tpf_pkg::ST_OUT;
					end
				end
			end
			tpf_pkg::ST_VT: begin
				ser_req.opa = OPW'(held_v_q);
				ser_req.opb = TPS;
				if (ser_rsp.done) state_d = tpf_pkg::ST_Q;
			end
			tpf_pkg::ST_Q: begin
				ser_req.op  = tpf_pkg::SER_DIV;
				ser_req.opa = t1_q;
				ser_req.opb = {1'b0, held_a_q};
				if (ser_rsp.done) state_d = tpf_pkg::ST_VV;
			end
			tpf_pkg::ST_VV: begin
				ser_req.opa = OPW'(held_v_q);
				ser_req.opb = {1'b0, held_v_q};
				if (ser_rsp.done) state_d = tpf_pkg::ST_DR;
			end
			tpf_pkg::ST_DR: begin
				ser_req.op  = tpf_pkg::SER_DIV;
				ser_req.opa = t2_q;
				ser_req.opb = {held_a_q, 1'b0};
				if (ser_rsp.done) state_d = tpf_pkg::ST_DC;
			end
			tpf_pkg::ST_DC: begin
				op_state = 1'b0;
				if (!dc_s[31] && dc_s != '0) begin
					state_d = tpf_pkg::ST_CM;
				end else begin
					state_d = tpf_pkg::ST_FIN;
				end
			end
			tpf_pkg::ST_CM: begin
				ser_req.opa = OPW'(dc_q[30:0]);
				ser_req.opb = TPS;
				if (ser_rsp.done) state_d = tpf_pkg::ST_CD;
			end
			tpf_pkg::ST_CD: begin
				// Ceiling division by adding the divisor less one.
				ser_req.op  = tpf_pkg::SER_DIV;
				ser_req.opa = t2_q + OPW'(held_v_q) - 1'b1;
				ser_req.opb = {1'b0, held_v_q};
				if (ser_rsp.done) state_d = tpf_pkg::ST_FIN;
			end
			tpf_pkg::ST_FIN: begin
				op_state = 1'b0;
				state_d  = tpf_pkg::ST_IDLE;
			end
			tpf_pkg::ST_SEL: begin
				op_state = 1'b0;
				state_d  = tpf_pkg::ST_P;
			end
			tpf_pkg::ST_P: begin
				ser_req.opa = OPW'(held_a_q);
				ser_req.opb = 32'(x_q);
				if (ser_rsp.done) state_d = tpf_pkg::ST_T1;
			end
			tpf_pkg::ST_T1: begin
				ser_req.op  = tpf_pkg::SER_DIV;
				ser_req.opa = p_q;
				ser_req.opb = TPS;
				if (ser_rsp.done) state_d = tpf_pkg::ST_T2M;
			end
			tpf_pkg::ST_T2M: begin
				ser_req.opa = p_q;
				ser_req.opb = 32'(x_q);
				if (ser_rsp.done) state_d = tpf_pkg::ST_T2;
			end
			tpf_pkg::ST_T2: begin
				ser_req.op  = tpf_pkg::SER_DIV;
				ser_req.opa = t2_q;
				ser_req.opb = DEN;
				if (ser_rsp.done) state_d = tpf_pkg::ST_T3M;
			end
			tpf_pkg::ST_T3M: begin
				ser_req.opa = OPW'(held_v_q);
				ser_req.opb = 32'(x_q);
				if (ser_rsp.done) state_d = tpf_pkg::ST_T3;
			end
			tpf_pkg::ST_T3: begin
				ser_req.op  = tpf_pkg::SER_DIV;
				ser_req.opa = t3_q;
				ser_req.opb = TPS;
				if (ser_rsp.done) state_d = tpf_pkg::ST_MIX;
			end
			tpf_pkg::ST_MIX: begin
				op_state = 1'b0;
				state_d  = tpf_pkg::ST_M1;
			end
			tpf_pkg::ST_M1: begin
				ser_req.opa = {{(OPW-32){vel_q[31]}}, vel_q};
				ser_req.opb = {16'd0, vscale_q};
				if (ser_rsp.done) state_d = tpf_pkg::ST_M2;
			end
			tpf_pkg::ST_M2: begin
				ser_req.opa = {{(OPW-35){err2_q[34]}}, err2_q};
				ser_req.opb = {16'd0, pgain_q};
				if (ser_rsp.done) state_d = tpf_pkg::ST_M3;
			end
			tpf_pkg::ST_M3: begin
				ser_req.opa = {{(OPW-32){cmd_q.heading[31]}}, cmd_q.heading};
				ser_req.opb = {16'd0, hgain_q};
				if (ser_rsp.done) state_d = tpf_pkg::ST_OUT;
			end
			tpf_pkg::ST_OUT: begin
				op_state = 1'b0;
				if (!rsp_valid_q || !rsp_stall) state_d = tpf_pkg::ST_IDLE;
			end
			default: begin
				op_state = 1'b0;
				state_d  = tpf_pkg::ST_IDLE;
			end
		endcase
		ser_req.go = op_state && !pend_q;
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tpf_pkg::ST_IDLE;
			pend_q      <= 1'b0;
			run_q       <= 1'b0;
			tick_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ser_req.go) begin
				pend_q <= 1'b1;
			end else if (ser_rsp.done) begin
				pend_q <= 1'b0;
			end
			if (state_q == tpf_pkg::ST_FIN) begin
				run_q  <= 1'b1;
				tick_q <= '0;
			end else if (state_q == tpf_pkg::ST_MIX) begin
				if ({1'b0, tick_nxt} >= total) begin
					run_q  <= 1'b0;
					tick_q <= '0;
				end else begin
					tick_q <= tick_nxt[CW-1:0];
				end
			end
			if (state_q == tpf_pkg::ST_OUT && (!rsp_valid_q || !rsp_stall)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			cmd_q <= cmd;
			if (cmd.action) begin
				held_v_q <= (cvel_q == '0) ? 31'd1 : cvel_q;
				held_a_q <= (accel_q == '0) ? 31'd1 : accel_q;
			end
		end
		if (ser_rsp.done) begin
			case (state_q)
				tpf_pkg::ST_VT:  t1_q <= ser_rsp.result;
				tpf_pkg::ST_Q: begin
					t1_q    <= ser_rsp.result;
					remnz_q <= (ser_rsp.rem != '0);
				end
				tpf_pkg::ST_VV:  t2_q <= ser_rsp.result;
				tpf_pkg::ST_DR: begin
					dr_q <= (ser_rsp.result[OPW-1:31] != '0) ? {31{1'b1}}
						: ser_rsp.result[30:0];
				end
				tpf_pkg::ST_CM:  t2_q <= ser_rsp.result;
				tpf_pkg::ST_CD:  t3_q <= ser_rsp.result;
				tpf_pkg::ST_P:   p_q  <= ser_rsp.result;
				tpf_pkg::ST_T1:  t1_q <= ser_rsp.result;
				tpf_pkg::ST_T2M: t2_q <= ser_rsp.result;
				tpf_pkg::ST_T2:  t2_q <= ser_rsp.result;
				tpf_pkg::ST_T3M: t3_q <= ser_rsp.result;
				tpf_pkg::ST_T3:  t3_q <= ser_rsp.result;
				tpf_pkg::ST_M1:  p_q  <= ser_rsp.result;
				tpf_pkg::ST_M2:  t1_q <= ser_rsp.result;
				tpf_pkg::ST_M3:  t2_q <= ser_rsp.result;
				default: ;
			endcase
		end
		case (state_q)
			tpf_pkg::ST_DC: begin
				dc_q <= dc_s;
				if (dc_s[31] || dc_s == '0) begin
					t3_q <= '0;
				end
			end
			tpf_pkg::ST_FIN: begin
				ramp_q   <= ramp_n;
				cruise_q <= cruise_n;
				brake_q  <= brake_n;
			end
			tpf_pkg::ST_SEL: begin
				if (tick_q < ramp_q) begin
					phase_q <= tpf_pkg::PH_RAMP;
					x_q     <= tick_q;
				end else if ({1'b0, tick_q} < rc) begin
					phase_q <= tpf_pkg::PH_CRUISE;
					x_q     <= tick_q - ramp_q;
				end else begin
					phase_q <= tpf_pkg::PH_BRAKE;
					x_q     <= tick_rel[CW-1:0];
				end
			end
			tpf_pkg::ST_MIX: begin
				vel_q  <= vel_s;
				err2_q <= err2_w;
			end
			tpf_pkg::ST_OUT: begin
				if (!rsp_valid_q || !rsp_stall) begin
					// An idle tick comes straight here and drives zero.
					rsp_q.speed_cmd <= idle_tick_q ? '0 : speed_s;
					rsp_q.twist_cmd <= idle_tick_q ? '0 : twist_s;
					rsp_q.running   <= run_q;
				end
			end
			default: ;
		endcase
	end

	// Marks a control tick that arrived with no profile running.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_tick_q <= 1'b0;
		end else if (cmd_take) begin
			idle_tick_q <= !cmd.action && !run_q;
		end
	end

endmodule

`default_nettype wire

// ===== dv/tpf_checker.sv =====
// Scoreboard for the trapezoid profile follower: watches the request, result and register ports.
// Predicts each control tick's drive command and compares it with the block's result.
// Depends on tpf_pkg for the request and result structs and the register codes.
`timescale 1ns / 1ps

module tpf_checker (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	input  wire logic          cmd_stall,
	input  wire tpf_pkg::cmd_t cmd,
	input  wire logic          rsp_valid,
	input  wire logic          rsp_stall,
	input  wire tpf_pkg::rsp_t rsp,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [4:0]    paddr,
	input  wire logic [31:0]   pwdata,
	input  wire logic          pready,
	output int                 fail_count,
	output int                 pending,
	output int                 checked
);

	localparam longint unsigned TICK_LIMIT = 65536;
	localparam longint unsigned TPS        = 100;

	logic [30:0] target_reg, cvel_reg, accel_reg;
	logic [15:0] vscale_reg, pgain_reg, hgain_reg;

	bit              moving;
	longint unsigned point_idx, ramp_pts, cruise_pts, brake_pts, vel_hold, acc_hold;
	longint          ramp_dist, cruise_dist;

	tpf_pkg::rsp_t drive_q[$];

	function automatic longint clamp_s32(input longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	// a*m*m/(2*TPS*TPS) split so that the product never overflows.
	function automatic longint unsigned brake_term(input longint unsigned m);
		longint unsigned d, p;
		d = 2 * TPS * TPS;
		p = acc_hold * m;
		return (p / d) * m + ((p % d) * m) / d;
	endfunction

	task automatic plan_move();
		longint unsigned v, a, vt, q, ramp, brake, dr, cruise;
		longint dc;
		v = (cvel_reg == 0) ? 1 : longint'(cvel_reg);
		a = (accel_reg == 0) ? 1 : longint'(accel_reg);
		vt = v * TPS;
		q = vt / a;
		ramp = q + 1;
		brake = q + (((vt % a) != 0) ? 1 : 0);
		dr = (v * v) / (2 * a);
		if (dr > 64'h7FFF_FFFF) dr = 64'h7FFF_FFFF;
		dc = clamp_s32(longint'(target_reg) - 2 * longint'(dr));
		cruise = 0;
		if (dc > 0) cruise = (longint'(dc) * TPS + v - 1) / v;
		if (ramp > TICK_LIMIT) ramp = TICK_LIMIT;
		if (cruise > TICK_LIMIT - ramp) cruise = TICK_LIMIT - ramp;
		if (brake > TICK_LIMIT - ramp - cruise) brake = TICK_LIMIT - ramp - cruise;
		vel_hold = v;
		acc_hold = a;
		ramp_dist = longint'(dr);
		cruise_dist = dc;
		ramp_pts = ramp;
		cruise_pts = cruise;
		brake_pts = brake;
		point_idx = 0;
		moving = 1'b1;
	endtask

	task automatic predict_drive(input tpf_pkg::cmd_t c, output tpf_pkg::rsp_t r);
		longint unsigned k;
		longint vel, pos, sum, err2, acc, speed, twist;
		speed = 0;
		twist = 0;
		if (moving) begin
			k = point_idx;
			if (k < ramp_pts) begin
				vel = longint'((acc_hold * k) / TPS);
				pos = longint'(brake_term(k));
			end else if (k < ramp_pts + cruise_pts) begin
				k = k - ramp_pts;
				vel = longint'(vel_hold);
				pos = ramp_dist + longint'((vel_hold * k) / TPS);
			end else begin
				k = k - ramp_pts - cruise_pts;
				vel = longint'(vel_hold) - longint'((acc_hold * k) / TPS);
				pos = cruise_dist + ramp_dist + longint'((vel_hold * k) / TPS)
					- longint'(brake_term(k));
			end
			vel = clamp_s32(vel);
			pos = clamp_s32(pos);
			sum = longint'(c.left_count) + longint'(c.right_count);
			err2 = 2 * pos - sum;
			acc = vel * longint'(vscale_reg) * 2 + err2 * longint'(pgain_reg);
			speed = clamp_s32(acc >>> 17);
			twist = clamp_s32((-(longint'(c.heading) * longint'(hgain_reg))) >>> 16);
			point_idx++;
			if (point_idx >= ramp_pts + cruise_pts + brake_pts) begin
				point_idx = 0;
				moving = 1'b0;
			end
		end
		r.speed_cmd = speed[31:0];
		r.twist_cmd = twist[31:0];
		r.running = moving;
	endtask

	always @(posedge clk or negedge arst_n) begin
		tpf_pkg::rsp_t want;
		if (!arst_n) begin
			target_reg = tpf_pkg::RST_TARGET;
			cvel_reg = tpf_pkg::RST_CVEL;
			accel_reg = tpf_pkg::RST_ACCEL;
			vscale_reg = tpf_pkg::RST_VSCALE;
			pgain_reg = tpf_pkg::RST_PGAIN;
			hgain_reg = tpf_pkg::RST_HGAIN;
			moving = 1'b0;
			point_idx = 0;
			ramp_pts = 0;
			cruise_pts = 0;
			brake_pts = 0;
			ramp_dist = 0;
			cruise_dist = 0;
			vel_hold = 0;
			acc_hold = 0;
			drive_q.delete();
			fail_count = 0;
			pending = 0;
			checked = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					tpf_pkg::REG_TARGET: target_reg = pwdata[30:0];
					tpf_pkg::REG_CVEL:   cvel_reg = pwdata[30:0];
					tpf_pkg::REG_ACCEL:  accel_reg = pwdata[30:0];
					tpf_pkg::REG_VSCALE: vscale_reg = pwdata[15:0];
					tpf_pkg::REG_PGAIN:  pgain_reg = pwdata[15:0];
					tpf_pkg::REG_HGAIN:  hgain_reg = pwdata[15:0];
					default: ;
				endcase
			end
			if (cmd_valid && !cmd_stall) begin
				if (cmd.action) begin
					plan_move();
				end else begin
					predict_drive(cmd, want);
					drive_q = {drive_q, want};
				end
			end
			if (rsp_valid && !rsp_stall) begin
				checked++;
				if (drive_q.size() == 0) begin
					$error("result arrived with no request waiting");
					fail_count++;
				end else begin
					want = drive_q.pop_front();
					if (rsp.speed_cmd !== want.speed_cmd) begin
						$error("speed_cmd: expected %0d, got %0d", want.speed_cmd, rsp.speed_cmd);
						fail_count++;
					end
					if (rsp.twist_cmd !== want.twist_cmd) begin
						$error("twist_cmd: expected %0d, got %0d", want.twist_cmd, rsp.twist_cmd);
						fail_count++;
					end
					if (rsp.running !== want.running) begin
						$error("running: expected %0b, got %0b", want.running, rsp.running);
						fail_count++;
					end
				end
			end
			pending = drive_q.size();
		end
	end

endmodule

// ===== dv/tb.sv =====
// Top of the trapezoid profile follower testbench: clock, reset, stimulus and verdict.
// Drives requests in bursts, stalls results, and programs the registers between phases.
// Depends on tpf_pkg, trapezoid_profile_follower and tpf_checker.
`timescale 1ns / 1ps

module tb;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          cmd_valid = 1'b0;
	logic          cmd_stall;
	tpf_pkg::cmd_t cmd = '0;
	logic          rsp_valid;
	logic          rsp_stall = 1'b0;
	tpf_pkg::rsp_t rsp;
	logic          psel = 1'b0;
	logic          penable = 1'b0;
	logic          pwrite = 1'b0;
	logic [4:0]    paddr = '0;
	logic [31:0]   pwdata = '0;
	logic [31:0]   prdata;
	logic          pready;

	int fail_count, pending, checked;
	int burst_left = 0;
	int sent = 0;
	int moves = 0;
	int settings = 0;
	int stall_mode = 0;
	int stall_cnt = 0;
	longint cur_target = 0;

	trapezoid_profile_follower uut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	tpf_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.fail_count(fail_count), .pending(pending), .checked(checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The receiver switches at random among four stall habits.
	always @(posedge clk) begin
		stall_cnt <= stall_cnt + 1;
		if (stall_cnt % 128 == 0) stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: rsp_stall <= 1'b0;
			1: rsp_stall <= 1'($urandom_range(0, 1));
			2: rsp_stall <= ($urandom_range(0, 7) == 0);
			default: rsp_stall <= ((stall_cnt % 32) < 20);
		endcase
	end

	task automatic send(input tpf_pkg::cmd_t c);
		if (burst_left == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 8);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (cmd_stall);
		burst_left--;
		sent++;
	endtask

	task automatic tick(input logic [31:0] l, input logic [31:0] r, input logic [31:0] h);
		tpf_pkg::cmd_t c;
		c.action = 1'b0;
		c.left_count = l;
		c.right_count = r;
		c.heading = h;
		send(c);
	endtask

	task automatic start_move();
		tpf_pkg::cmd_t c;
		c.action = 1'b1;
		c.left_count = $urandom;
		c.right_count = $urandom;
		c.heading = $urandom;
		moves++;
		send(c);
	endtask

	task automatic set_reg(input logic [2:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		if (idx == tpf_pkg::REG_TARGET) cur_target = longint'(val[30:0]);
	endtask

	// Waits until the block has gone quiet; a start gives no result, so allow its run time.
	task automatic settle();
		cmd_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		wait (pending == 0);
		repeat (400) @(posedge clk);
		settings++;
	endtask

	task automatic rand_tick();
		logic [31:0] base, l, r, h;
		if ($urandom_range(0, 4) == 0) begin
			l = $urandom;
			r = $urandom;
		end else begin
			base = $urandom_range(0, int'(cur_target > 0 ? cur_target : 1));
			l = base + $urandom_range(0, 1 << 18) - (1 << 17);
			r = base + $urandom_range(0, 1 << 18) - (1 << 17);
		end
		h = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 24) - (1 << 23);
		tick(l, r, h);
	endtask

	task automatic rand_setting();
		longint v, a, dr, t;
		int q;
		case ($urandom_range(0, 7))
			0: v = 0;
			1: v = $urandom & 32'h7FFF_FFFF;
			default: v = $urandom_range(1, 1 << 24);
		endcase
		q = $urandom_range(0, 15);
		a = ((v == 0 ? 1 : v) * 100) / (q + 1);
		if (a > 64'h7FFF_FFFF) a = 64'h7FFF_FFFF;
		if ($urandom_range(0, 9) == 0) a = 0;
		dr = (v * v) / (2 * (a == 0 ? 1 : a));
		t = ($urandom_range(0, 2) == 0) ? dr : 2 * dr + (v * $urandom_range(0, 10)) / 100;
		if ($urandom_range(0, 9) == 0) t = $urandom & 32'h7FFF_FFFF;
		if (t > 64'h7FFF_FFFF) t = 64'h7FFF_FFFF;
		set_reg(tpf_pkg::REG_TARGET, t[31:0]);
		set_reg(tpf_pkg::REG_CVEL, v[31:0]);
		set_reg(tpf_pkg::REG_ACCEL, a[31:0]);
		set_reg(tpf_pkg::REG_VSCALE,
			($urandom_range(0, 5) == 0) ? 32'h0000_FFFF : $urandom_range(0, 8000));
		set_reg(tpf_pkg::REG_PGAIN,
			($urandom_range(0, 5) == 0) ? 32'd0 : $urandom_range(0, 65535));
		set_reg(tpf_pkg::REG_HGAIN, $urandom_range(0, 65535));
	endtask

	initial begin
		int n;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default registers: idle ticks, a short move, and a restart while running.
		tick(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		tick(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		start_move();
		tick(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
		tick(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
		tick(0, 0, 0);
		tick(32'h0001_0000, 32'hFFFF_0000, 32'h0005_0000);
		start_move();
		tick(0, 0, 32'hFFFF_FFFF);
		settle();

		// Zero speed and acceleration with the longest target: long cruise, cut at the limit.
		set_reg(tpf_pkg::REG_TARGET, 32'h7FFF_FFFF);
		set_reg(tpf_pkg::REG_CVEL, 0);
		set_reg(tpf_pkg::REG_ACCEL, 0);
		set_reg(tpf_pkg::REG_VSCALE, 32'h0000_FFFF);
		set_reg(tpf_pkg::REG_PGAIN, 32'h0000_FFFF);
		set_reg(tpf_pkg::REG_HGAIN, 32'h0000_FFFF);
		start_move();
		tick(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		tick(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		tick(0, 0, 0);
		settle();

		// Fastest speed and acceleration, zero target, zero gains.
		set_reg(tpf_pkg::REG_TARGET, 0);
		set_reg(tpf_pkg::REG_CVEL, 32'h7FFF_FFFF);
		set_reg(tpf_pkg::REG_ACCEL, 32'h7FFF_FFFF);
		set_reg(tpf_pkg::REG_VSCALE, 0);
		set_reg(tpf_pkg::REG_PGAIN, 0);
		set_reg(tpf_pkg::REG_HGAIN, 0);
		start_move();
		tick(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		tick(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		// Gains change mid-run; the latched speed and acceleration stay.
		settle();
		set_reg(tpf_pkg::REG_PGAIN, 32'h0000_FFFF);
		set_reg(tpf_pkg::REG_CVEL, 32'd65536);
		tick(32'h8000_0000, 32'h8000_0000, 32'h1234_5678);
		settle();

		while (sent < 650) begin
			rand_setting();
			start_move();
			n = $urandom_range(5, 40);
			repeat (n) begin
				case ($urandom_range(0, 19))
					0: start_move();
					default: rand_tick();
				endcase
			end
			settle();
		end

		repeat (300) @(posedge clk);
		$display("Sent %0d requests (%0d move starts) across %0d register settings.",
			sent, moves, settings);
		$display("Checked %0d drive results against the prediction.", checked);
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#50_000_000;
		$display("Timed out waiting for the block.");
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== trapezoid_profile_follower.f =====
hdl/tpf_pkg.sv
hdl/tpf_serial.sv
hdl/trapezoid_profile_follower.sv
dv/tpf_checker.sv
dv/tb.sv
